FILE: design/ahhr_pkg.sv
// Shared types, widths and helpers for the access history hot region detector.
// No dependencies; every other design file refers to this package by scoped names.

package ahhr_pkg;

    // Window geometry.
    localparam int HISTORY_DEPTH = 64;
    localparam int HOT_DIVISOR   = 10;
    localparam int HOT_THRESHOLD =
        (HISTORY_DEPTH / HOT_DIVISOR < 1) ? 1 : HISTORY_DEPTH / HOT_DIVISOR;

    // Field widths of the channels.
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 64;
    localparam int FIELD_W = 7;

    // Width of a count of entries, able to hold the depth itself.
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // Hit counting is done in groups of eight cells.
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = $clog2(GRP_SIZE + 1);
    localparam int NUM_GRP  = (HISTORY_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    // Commands carried on the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_EVICT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // What a window cell does in one cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_PREV,
        CELL_LOAD_NEXT,
        CELL_DROP,
        CELL_MARK,
        CELL_KILL
    } t_cell_op;

    // Control handed to every cell: its operation and the range under test.
    typedef struct packed {
        t_cell_op            op;
        logic [ADDR_W-1:0]   q_start;
        logic [ADDR_W-1:0]   q_end;
    } t_cell_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GROUP,
        S_TOTAL,
        S_TALLY,
        S_COMPACT,
        S_FIN
    } t_state;

    // Reduce an entry count to the width of a result field (modulo 2^FIELD_W).
    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] t;
        t = (CNT_W + FIELD_W)'(v);
        return t[FIELD_W-1:0];
    endfunction

endpackage

FILE: design/ahhr_if.sv
// Handshake interfaces for the command and result channels.
// Depends on ahhr_pkg for the field widths.

interface ahhr_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ahhr_pkg::CMD_W-1:0]    command;
    logic [ahhr_pkg::ADDR_W-1:0]   start_address;
    logic [ahhr_pkg::ADDR_W-1:0]   range_length;

    modport source (output valid, command, start_address, range_length, input ready);
    modport sink   (input valid, command, start_address, range_length, output ready);
endinterface

interface ahhr_res_if;
    logic                          valid;
    logic                          ready;
    logic                          is_hot;
    logic [ahhr_pkg::FIELD_W-1:0]  overlap_count;
    logic [ahhr_pkg::FIELD_W-1:0]  entries_held;

    modport source (output valid, is_hot, overlap_count, entries_held, input ready);
    modport sink   (input valid, is_hot, overlap_count, entries_held, output ready);
endinterface

FILE: design/access_history_hot_region_detector.sv
// Top level: sequencer, chain of window cells and hit counter.
// Depends on ahhr_pkg, ahhr_if, ahhr_cell and ahhr_popcount.
//
//  Channel   Port    Direction  Beat contents
//  -------   -----   ---------  ---------------------------------------------
//  command   i_cmd   in         command, start_address, range_length
//  result    o_res   out        is_hot, overlap_count, entries_held
//
// One beat is taken at a time. A record or clear beat passes through S_EXEC and S_FIN
// to the output register; a query passes through S_EXEC, S_GROUP, S_TOTAL, S_TALLY and
// S_FIN. An evict also runs compaction passes of the cell chain in S_COMPACT.
// Reset clears the cell valid bits, the fill count and the sequencer at once.
// A new command beat is taken while a finished result still waits on o_res;
// the next result then holds the sequencer until the output register is free.

module access_history_hot_region_detector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ahhr_cmd_if.sink      i_cmd,
    ahhr_res_if.source    o_res
);

    localparam int N = ahhr_pkg::HISTORY_DEPTH;

    ahhr_pkg::t_state              r_state;
    ahhr_pkg::t_state              n_state;
    ahhr_pkg::t_cmd                r_cmd;
    logic [ahhr_pkg::ADDR_W-1:0]   r_addr;
    logic [ahhr_pkg::ADDR_W-1:0]   r_end;
    logic [ahhr_pkg::CNT_W-1:0]    r_fill;
    logic [ahhr_pkg::CNT_W-1:0]    n_fill;
    logic                          r_phase;
    logic                          r_out_valid;
    logic                          r_out_hot;
    logic [ahhr_pkg::FIELD_W-1:0]  r_out_count;
    logic [ahhr_pkg::FIELD_W-1:0]  r_out_held;

    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_compact;
    logic [ahhr_pkg::CNT_W-1:0]    w_total;
    logic                          w_grp_en;
    logic                          w_sum_en;

    logic [ahhr_pkg::ADDR_W-1:0]   w_start     [N];
    logic [ahhr_pkg::ADDR_W-1:0]   w_stop      [N];
    logic [ahhr_pkg::ADDR_W-1:0]   w_prev_start[N];
    logic [ahhr_pkg::ADDR_W-1:0]   w_prev_stop [N];
    logic [ahhr_pkg::ADDR_W-1:0]   w_next_start[N];
    logic [ahhr_pkg::ADDR_W-1:0]   w_next_stop [N];
    logic [N-1:0]                  w_valid;
    logic [N-1:0]                  w_prev_valid;
    logic [N-1:0]                  w_next_valid;
    logic [N-1:0]                  w_hit;
    logic [N-1:0]                  w_gap;
    logic [N-1:0]                  w_swap_lo;
    logic [N-1:0]                  w_swap_hi;
    ahhr_pkg::t_cell_ctl           w_ctl       [N];

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ahhr_pkg::S_IDLE);

    // The window is compact when no empty cell sits below a valid one.
    assign w_compact = !(|w_gap);

    // Neighbor wiring of the cell chain; the newest entry enters at cell 0.
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_start[g] = r_addr;
            assign w_prev_stop[g]  = r_end;
            assign w_prev_valid[g] = 1'b1;
            assign w_swap_hi[g]    = 1'b0;
        end else begin : g_body
            assign w_prev_start[g] = w_start[g-1];
            assign w_prev_stop[g]  = w_stop[g-1];
            assign w_prev_valid[g] = w_valid[g-1];
            assign w_swap_hi[g]    = w_swap_lo[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_next_start[g] = '0;
            assign w_next_stop[g]  = '0;
            assign w_next_valid[g] = 1'b0;
            assign w_gap[g]        = 1'b0;
        end else begin : g_link
            assign w_next_start[g] = w_start[g+1];
            assign w_next_stop[g]  = w_stop[g+1];
            assign w_next_valid[g] = w_valid[g+1];
            assign w_gap[g]        = !w_valid[g] && w_valid[g+1];
        end

        // Odd-even exchange: pairs starting at the current phase move a valid
        // entry down into an empty cell.
        assign w_swap_lo[g] = w_gap[g] && (r_phase == 1'(g % 2));

        // Per-cell operation from the sequencer state.
        always_comb begin
            w_ctl[g].q_start = r_addr;
            w_ctl[g].q_end   = r_end;
            w_ctl[g].op      = ahhr_pkg::CELL_HOLD;
            unique case (r_state)
                ahhr_pkg::S_EXEC: begin
                    if (r_cmd == ahhr_pkg::CMD_RECORD) begin
                        w_ctl[g].op = ahhr_pkg::CELL_LOAD_PREV;
                    end else if (r_cmd == ahhr_pkg::CMD_CLEAR) begin
                        w_ctl[g].op = ahhr_pkg::CELL_DROP;
                    end else begin
                        w_ctl[g].op = ahhr_pkg::CELL_MARK;
                    end
                end
                ahhr_pkg::S_GROUP: begin
                    if (r_cmd == ahhr_pkg::CMD_EVICT) begin
                        w_ctl[g].op = ahhr_pkg::CELL_KILL;
                    end
                end
                ahhr_pkg::S_COMPACT: begin
                    if (!w_compact && w_swap_lo[g]) begin
                        w_ctl[g].op = ahhr_pkg::CELL_LOAD_NEXT;
                    end else if (!w_compact && w_swap_hi[g]) begin
                        w_ctl[g].op = ahhr_pkg::CELL_DROP;
                    end
                end
                default: begin
                end
            endcase
        end

        ahhr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_prev_start (w_prev_start[g]),
            .i_prev_end   (w_prev_stop[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_next_start (w_next_start[g]),
            .i_next_end   (w_next_stop[g]),
            .i_next_valid (w_next_valid[g]),
            .o_start      (w_start[g]),
            .o_end        (w_stop[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g])
        );
    end

    assign w_grp_en = (r_state == ahhr_pkg::S_GROUP);
    assign w_sum_en = (r_state == ahhr_pkg::S_TOTAL);

    ahhr_popcount u_popcount (
        .i_clk    (i_clk),
        .i_hit    (w_hit),
        .i_grp_en (w_grp_en),
        .i_sum_en (w_sum_en),
        .o_total  (w_total)
    );

    // Next state and fill count.
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        unique case (r_state)
            ahhr_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ahhr_pkg::S_EXEC;
                end
            end
            ahhr_pkg::S_EXEC: begin
                unique case (r_cmd)
                    ahhr_pkg::CMD_RECORD: begin
                        if (r_fill != ahhr_pkg::CNT_W'(N)) begin
                            n_fill = r_fill + ahhr_pkg::CNT_W'(1);
                        end
                        n_state = ahhr_pkg::S_FIN;
                    end
                    ahhr_pkg::CMD_CLEAR: begin
                        n_fill  = '0;
                        n_state = ahhr_pkg::S_FIN;
                    end
                    default: n_state = ahhr_pkg::S_GROUP;
                endcase
            end
            ahhr_pkg::S_GROUP: n_state = ahhr_pkg::S_TOTAL;
            ahhr_pkg::S_TOTAL: n_state = ahhr_pkg::S_TALLY;
            ahhr_pkg::S_TALLY: begin
                if (r_cmd == ahhr_pkg::CMD_EVICT) begin
                    n_fill  = r_fill - w_total;
                    n_state = ahhr_pkg::S_COMPACT;
                end else begin
                    n_state = ahhr_pkg::S_FIN;
                end
            end
            ahhr_pkg::S_COMPACT: begin
                if (w_compact) begin
                    n_state = ahhr_pkg::S_FIN;
                end
            end
            ahhr_pkg::S_FIN: begin
                if (w_slot_free) begin
                    n_state = ahhr_pkg::S_IDLE;
                end
            end
            default: n_state = ahhr_pkg::S_IDLE;
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahhr_pkg::S_IDLE;
            r_fill  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (r_state == ahhr_pkg::S_COMPACT) begin
                r_phase <= !r_phase;
            end
        end
    end

    // Command beat capture; the range end wraps modulo 2^64.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= ahhr_pkg::t_cmd'(i_cmd.command);
            r_addr <= i_cmd.start_address;
            r_end  <= i_cmd.start_address + i_cmd.range_length;
        end
    end

    // Result register; it is loaded once the previous beat has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ahhr_pkg::S_FIN && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ahhr_pkg::S_FIN && w_slot_free) begin
            r_out_hot   <= (r_cmd == ahhr_pkg::CMD_QUERY) &&
                           (w_total >= ahhr_pkg::CNT_W'(ahhr_pkg::HOT_THRESHOLD));
            r_out_count <= (r_cmd == ahhr_pkg::CMD_QUERY || r_cmd == ahhr_pkg::CMD_EVICT)
                           ? ahhr_pkg::to_field(w_total) : '0;
            r_out_held  <= ahhr_pkg::to_field(r_fill);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.is_hot        = r_out_hot;
    assign o_res.overlap_count = r_out_count;
    assign o_res.entries_held  = r_out_held;

endmodule

FILE: design/ahhr_cell.sv
// One window cell: holds a start and end address, a valid bit and a hit flag.
// Depends on ahhr_pkg for the cell control struct and widths.

module ahhr_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ahhr_pkg::t_cell_ctl          i_ctl,
    input  logic [ahhr_pkg::ADDR_W-1:0]  i_prev_start,
    input  logic [ahhr_pkg::ADDR_W-1:0]  i_prev_end,
    input  logic                         i_prev_valid,
    input  logic [ahhr_pkg::ADDR_W-1:0]  i_next_start,
    input  logic [ahhr_pkg::ADDR_W-1:0]  i_next_end,
    input  logic                         i_next_valid,
    output logic [ahhr_pkg::ADDR_W-1:0]  o_start,
    output logic [ahhr_pkg::ADDR_W-1:0]  o_end,
    output logic                         o_valid,
    output logic                         o_hit
);

    logic [ahhr_pkg::ADDR_W-1:0] r_start;
    logic [ahhr_pkg::ADDR_W-1:0] r_end;
    logic                        r_valid;
    logic                        r_hit;
    logic                        w_overlap;

    // Ranges overlap unless the query ends at or before this entry starts,
    // or starts at or after this entry ends.
    assign w_overlap = !((i_ctl.q_end <= r_start) || (i_ctl.q_start >= r_end));

    // Control bits: valid and hit flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                ahhr_pkg::CELL_LOAD_PREV: r_valid <= i_prev_valid;
                ahhr_pkg::CELL_LOAD_NEXT: r_valid <= i_next_valid;
                ahhr_pkg::CELL_DROP:      r_valid <= 1'b0;
                ahhr_pkg::CELL_MARK:      r_hit   <= r_valid && w_overlap;
                ahhr_pkg::CELL_KILL:      r_valid <= r_valid && !r_hit;
                default: begin
                end
            endcase
        end
    end

    // Address payload moves between neighbors.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            ahhr_pkg::CELL_LOAD_PREV: begin
                r_start <= i_prev_start;
                r_end   <= i_prev_end;
            end
            ahhr_pkg::CELL_LOAD_NEXT: begin
                r_start <= i_next_start;
                r_end   <= i_next_end;
            end
            default: begin
            end
        endcase
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

FILE: design/ahhr_popcount.sv
// Two-stage registered count of the cell hit flags: group sums, then a total.
// Depends on ahhr_pkg for the depth and group geometry.

module ahhr_popcount (
    input  logic                                 i_clk,
    input  logic [ahhr_pkg::HISTORY_DEPTH-1:0]   i_hit,
    input  logic                                 i_grp_en,
    input  logic                                 i_sum_en,
    output logic [ahhr_pkg::CNT_W-1:0]           o_total
);

    localparam int PAD_W = ahhr_pkg::NUM_GRP * ahhr_pkg::GRP_SIZE;

    logic [PAD_W-1:0]            w_pad;
    logic [ahhr_pkg::GRP_W-1:0]  n_grp [ahhr_pkg::NUM_GRP];
    logic [ahhr_pkg::GRP_W-1:0]  r_grp [ahhr_pkg::NUM_GRP];
    logic [ahhr_pkg::CNT_W-1:0]  n_total;
    logic [ahhr_pkg::CNT_W-1:0]  r_total;

    assign w_pad = PAD_W'(i_hit);

    // Each group adds its eight flags.
    always_comb begin
        for (int g = 0; g < ahhr_pkg::NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < ahhr_pkg::GRP_SIZE; k++) begin
                n_grp[g] = n_grp[g] + ahhr_pkg::GRP_W'(w_pad[g * ahhr_pkg::GRP_SIZE + k]);
            end
        end
    end

    // The group sums are added into the total.
    always_comb begin
        n_total = '0;
        for (int g = 0; g < ahhr_pkg::NUM_GRP; g++) begin
            n_total = n_total + ahhr_pkg::CNT_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_en) begin
            r_grp <= n_grp;
        end
        if (i_sum_en) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule
